>>> rtl/core/ssgs_pkg.sv
// Package for the spectral site gain shaper: payload structs, register
// indexes, pipeline stage layout and fixed-point constants. No dependencies.
package ssgs_pkg;

  // Transform length; bins at or above half of it pass with unity gain.
  localparam int FFT_SIZE = 4096;

  localparam int CORNER_W = 12;
  localparam int GAIN_W   = 16;
  localparam int BIN_W    = 11;
  localparam int DATA_W   = 32;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [GAIN_W-1:0] UNITY_GAIN = 16'd4096;

  // Width of (bin - corner) * |gain difference| and of the products x * g.
  localparam int NUM_W  = BIN_W + GAIN_W;
  localparam int PROD_W = DATA_W + GAIN_W + 1;

  // Pipeline layout: entry, setup, multiply, four divider stages, gain, product.
  localparam int STAGES        = 9;
  localparam int ST_ENTRY      = 0;
  localparam int ST_SETUP      = 1;
  localparam int ST_MUL        = 2;
  localparam int ST_DIV0       = 3;
  localparam int DIV_STAGES    = 4;
  localparam int BITS_PER_DIV  = GAIN_W / DIV_STAGES;
  localparam int ST_GAIN       = 7;
  localparam int ST_PROD       = 8;

  typedef enum logic [3:0] {
    REG_CORNER_LOW        = 4'd0,
    REG_CORNER_MID_BOTTOM = 4'd1,
    REG_CORNER_MID        = 4'd2,
    REG_CORNER_HIGH       = 4'd3,
    REG_CORNER_HIGH_TOP   = 4'd4,
    REG_CORNER_MAX        = 4'd5,
    REG_GAIN_SHORT        = 4'd6,
    REG_GAIN_LONG         = 4'd7
  } cfg_reg_e;

  typedef enum logic [2:0] {
    SEG_UNITY,
    SEG_RAMP_LONG,
    SEG_FLAT_LONG,
    SEG_RAMP_SHORT,
    SEG_FLAT_SHORT,
    SEG_RAMP_TOP
  } seg_e;

  typedef struct packed {
    logic [BIN_W-1:0]         bin_index;
    logic signed [DATA_W-1:0] spec_re;
    logic signed [DATA_W-1:0] spec_im;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] scaled_re;
    logic signed [DATA_W-1:0] scaled_im;
    logic [GAIN_W-1:0]        gain_used;
    logic                     saturated;
  } out_item_t;

  typedef struct packed {
    logic [BIN_W-1:0]         bin;
    seg_e                     seg;
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
    logic [GAIN_W-1:0]        base;
    logic [GAIN_W-1:0]        mag;
    logic                     neg;
    logic [BIN_W-1:0]         ofs;
    logic [CORNER_W-1:0]      den;
    logic [NUM_W-1:0]         rem;
    logic [GAIN_W-1:0]        quo;
    logic [GAIN_W-1:0]        gain;
    logic signed [PROD_W-1:0] prod_re;
    logic signed [PROD_W-1:0] prod_im;
  } pipe_t;

endpackage

>>> rtl/core/spectral_site_gain_shaper.sv
// Spectral site gain shaper: piecewise linear gain over bin index applied
// to one complex bin per item. Depends on ssgs_pkg.
//
//  Channel  | Handshake                  | Payload
//  ---------+----------------------------+---------------------------------
//  input    | in_valid_i / in_ready_o    | in_item_i  (bin, re, im)
//  output   | out_valid_o / out_ready_i  | out_item_o (re, im, gain, sat)
//  config   | cfg_we_i, no wait          | cfg_idx_i, cfg_wdata_i
//
// One item enters per cycle while in_ready_o is high; each item passes nine
// pipeline registers and then the output register, the first loaded at the
// edge that accepts it. The ramp division takes four of those stages, four
// quotient bits each, and sets the depth. Reset clears the valid bits and
// loads the register reset values. A stalled output holds its item, and each
// stage holds only while the stage after it is full and cannot move, so empty
// slots close up and no item is lost or repeated.
module spectral_site_gain_shaper (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  ssgs_pkg::in_item_t                  in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output ssgs_pkg::out_item_t                 out_item_o,
  input  logic                                cfg_we_i,
  input  logic [ssgs_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ssgs_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  localparam int CW = ssgs_pkg::CORNER_W;
  localparam int GW = ssgs_pkg::GAIN_W;

  // Configuration registers.
  logic [CW-1:0] lo_q, mb_q, md_q, hi_q, ht_q, mx_q;
  logic [GW-1:0] gs_q, gl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q <= '0;
      mb_q <= '0;
      md_q <= '0;
      hi_q <= '0;
      ht_q <= 12'd2048;
      mx_q <= 12'd2048;
      gs_q <= 16'd4096;
      gl_q <= 16'd4096;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ssgs_pkg::REG_CORNER_LOW:        lo_q <= cfg_wdata_i[CW-1:0];
        ssgs_pkg::REG_CORNER_MID_BOTTOM: mb_q <= cfg_wdata_i[CW-1:0];
        ssgs_pkg::REG_CORNER_MID:        md_q <= cfg_wdata_i[CW-1:0];
        ssgs_pkg::REG_CORNER_HIGH:       hi_q <= cfg_wdata_i[CW-1:0];
        ssgs_pkg::REG_CORNER_HIGH_TOP:   ht_q <= cfg_wdata_i[CW-1:0];
        ssgs_pkg::REG_CORNER_MAX:        mx_q <= cfg_wdata_i[CW-1:0];
        ssgs_pkg::REG_GAIN_SHORT:        gs_q <= cfg_wdata_i;
        ssgs_pkg::REG_GAIN_LONG:         gl_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // The lowest corner never passes the long-band start, and the top corner
  // never falls below the ramp-back start.
  logic [CW-1:0] lo_eff, mx_eff;
  assign lo_eff = (lo_q > mb_q) ? mb_q : lo_q;
  assign mx_eff = (mx_q < ht_q) ? ht_q : mx_q;

  // Pipeline registers and flow control.
  ssgs_pkg::pipe_t pipe_q [ssgs_pkg::STAGES];
  ssgs_pkg::pipe_t pipe_d [ssgs_pkg::STAGES];
  logic [ssgs_pkg::STAGES-1:0] valid_q;
  logic [ssgs_pkg::STAGES-1:0] free;
  logic                        out_free;
  logic                        out_valid_q;
  ssgs_pkg::out_item_t         out_q, out_d;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    free[ssgs_pkg::STAGES-1] = !valid_q[ssgs_pkg::STAGES-1] || out_free;
    for (int s = ssgs_pkg::STAGES - 2; s >= 0; s--) begin
      free[s] = !valid_q[s] || free[s+1];
    end
  end

  assign in_ready_o = free[0];

  // Stage logic.
  logic [CW-1:0]    bin12, s_bin12, c0, c1;
  logic [GW-1:0]    ga, gb;
  logic signed [GW:0] diff;
  logic [ssgs_pkg::NUM_W-1:0] trial;
  logic signed [ssgs_pkg::PROD_W:0] rnd_re, rnd_im;
  logic signed [ssgs_pkg::PROD_W-12:0] q_re, q_im;
  logic sat_re, sat_im;

  always_comb begin
    bin12   = {1'b0, in_item_i.bin_index};
    s_bin12 = {1'b0, pipe_q[ssgs_pkg::ST_ENTRY].bin};
    // Flat bands get a length of one and a zero magnitude, so the divider returns zero for them.
    c0      = '0;
    c1      = 12'd1;
    ga      = ssgs_pkg::UNITY_GAIN;
    gb      = ssgs_pkg::UNITY_GAIN;
    diff    = '0;
    trial   = '0;

    // Entry: pick the band the bin falls in.
    pipe_d[ssgs_pkg::ST_ENTRY]     = '0;
    pipe_d[ssgs_pkg::ST_ENTRY].bin = in_item_i.bin_index;
    pipe_d[ssgs_pkg::ST_ENTRY].re  = in_item_i.spec_re;
    pipe_d[ssgs_pkg::ST_ENTRY].im  = in_item_i.spec_im;
    if (in_item_i.bin_index == '0 || 32'(bin12) >= ssgs_pkg::FFT_SIZE / 2) begin
      pipe_d[ssgs_pkg::ST_ENTRY].seg = ssgs_pkg::SEG_UNITY;
    end else if (bin12 < lo_eff) begin
      pipe_d[ssgs_pkg::ST_ENTRY].seg = ssgs_pkg::SEG_UNITY;
    end else if (bin12 < mb_q) begin
      pipe_d[ssgs_pkg::ST_ENTRY].seg = ssgs_pkg::SEG_RAMP_LONG;
    end else if (bin12 < md_q) begin
      pipe_d[ssgs_pkg::ST_ENTRY].seg = ssgs_pkg::SEG_FLAT_LONG;
    end else if (bin12 < hi_q) begin
      pipe_d[ssgs_pkg::ST_ENTRY].seg = ssgs_pkg::SEG_RAMP_SHORT;
    end else if (bin12 < ht_q) begin
      pipe_d[ssgs_pkg::ST_ENTRY].seg = ssgs_pkg::SEG_FLAT_SHORT;
    end else if (bin12 < mx_eff) begin
      pipe_d[ssgs_pkg::ST_ENTRY].seg = ssgs_pkg::SEG_RAMP_TOP;
    end else begin
      pipe_d[ssgs_pkg::ST_ENTRY].seg = ssgs_pkg::SEG_UNITY;
    end

    // Setup: ramp end points, distance into the ramp and its length.
    pipe_d[ssgs_pkg::ST_SETUP] = pipe_q[ssgs_pkg::ST_ENTRY];
    case (pipe_q[ssgs_pkg::ST_ENTRY].seg)
      ssgs_pkg::SEG_RAMP_LONG: begin
        c0 = lo_eff; c1 = mb_q; ga = ssgs_pkg::UNITY_GAIN; gb = gl_q;
      end
      ssgs_pkg::SEG_FLAT_LONG: begin
        ga = gl_q; gb = gl_q;
      end
      ssgs_pkg::SEG_RAMP_SHORT: begin
        c0 = md_q; c1 = hi_q; ga = gl_q; gb = gs_q;
      end
      ssgs_pkg::SEG_FLAT_SHORT: begin
        ga = gs_q; gb = gs_q;
      end
      ssgs_pkg::SEG_RAMP_TOP: begin
        c0 = ht_q; c1 = mx_eff; ga = gs_q; gb = ssgs_pkg::UNITY_GAIN;
      end
      default: begin
        ga = ssgs_pkg::UNITY_GAIN; gb = ssgs_pkg::UNITY_GAIN;
      end
    endcase
    diff = signed'({1'b0, gb}) - signed'({1'b0, ga});
    pipe_d[ssgs_pkg::ST_SETUP].base = ga;
    pipe_d[ssgs_pkg::ST_SETUP].neg  = diff[GW];
    pipe_d[ssgs_pkg::ST_SETUP].mag  = diff[GW] ? GW'(-diff) : diff[GW-1:0];
    pipe_d[ssgs_pkg::ST_SETUP].ofs  = ssgs_pkg::BIN_W'(s_bin12 - c0);
    pipe_d[ssgs_pkg::ST_SETUP].den  = c1 - c0;

    // Numerator of the ramp; flat bands carry a zero magnitude.
    pipe_d[ssgs_pkg::ST_MUL]     = pipe_q[ssgs_pkg::ST_SETUP];
    pipe_d[ssgs_pkg::ST_MUL].rem = pipe_q[ssgs_pkg::ST_SETUP].ofs *
                                   pipe_q[ssgs_pkg::ST_SETUP].mag;
    pipe_d[ssgs_pkg::ST_MUL].quo = '0;

    // Restoring division, high quotient bits first. The quotient is known
    // to fit in the gain width because the distance is below the length.
    for (int j = 0; j < ssgs_pkg::DIV_STAGES; j++) begin
      pipe_d[ssgs_pkg::ST_DIV0+j] = pipe_q[ssgs_pkg::ST_DIV0+j-1];
      for (int b = 0; b < ssgs_pkg::BITS_PER_DIV; b++) begin
        trial = ssgs_pkg::NUM_W'(pipe_q[ssgs_pkg::ST_DIV0+j-1].den) <<
                (GW - 1 - j * ssgs_pkg::BITS_PER_DIV - b);
        if (pipe_d[ssgs_pkg::ST_DIV0+j].rem >= trial) begin
          pipe_d[ssgs_pkg::ST_DIV0+j].rem = pipe_d[ssgs_pkg::ST_DIV0+j].rem - trial;
          pipe_d[ssgs_pkg::ST_DIV0+j].quo[GW-1-j*ssgs_pkg::BITS_PER_DIV-b] = 1'b1;
        end
      end
    end

    // Gain: start gain moved toward the end gain by a step truncated toward zero.
    pipe_d[ssgs_pkg::ST_GAIN] = pipe_q[ssgs_pkg::ST_GAIN-1];
    pipe_d[ssgs_pkg::ST_GAIN].gain = pipe_q[ssgs_pkg::ST_GAIN-1].neg ?
        pipe_q[ssgs_pkg::ST_GAIN-1].base - pipe_q[ssgs_pkg::ST_GAIN-1].quo :
        pipe_q[ssgs_pkg::ST_GAIN-1].base + pipe_q[ssgs_pkg::ST_GAIN-1].quo;

    // Full-precision products.
    pipe_d[ssgs_pkg::ST_PROD] = pipe_q[ssgs_pkg::ST_GAIN];
    pipe_d[ssgs_pkg::ST_PROD].prod_re = pipe_q[ssgs_pkg::ST_GAIN].re *
                                        signed'({1'b0, pipe_q[ssgs_pkg::ST_GAIN].gain});
    pipe_d[ssgs_pkg::ST_PROD].prod_im = pipe_q[ssgs_pkg::ST_GAIN].im *
                                        signed'({1'b0, pipe_q[ssgs_pkg::ST_GAIN].gain});

    // Round half up, drop the twelve fraction bits, then saturate.
    rnd_re = signed'(pipe_q[ssgs_pkg::ST_PROD].prod_re) + (ssgs_pkg::PROD_W+1)'(2048);
    rnd_im = signed'(pipe_q[ssgs_pkg::ST_PROD].prod_im) + (ssgs_pkg::PROD_W+1)'(2048);
    q_re   = rnd_re[ssgs_pkg::PROD_W:12];
    q_im   = rnd_im[ssgs_pkg::PROD_W:12];
    sat_re = q_re[ssgs_pkg::PROD_W-12:31] != '0 && q_re[ssgs_pkg::PROD_W-12:31] != '1;
    sat_im = q_im[ssgs_pkg::PROD_W-12:31] != '0 && q_im[ssgs_pkg::PROD_W-12:31] != '1;
    out_d.scaled_re = !sat_re ? q_re[31:0] :
                      (q_re[ssgs_pkg::PROD_W-12] ? 32'sh8000_0000 : 32'sh7fff_ffff);
    out_d.scaled_im = !sat_im ? q_im[31:0] :
                      (q_im[ssgs_pkg::PROD_W-12] ? 32'sh8000_0000 : 32'sh7fff_ffff);
    out_d.gain_used = pipe_q[ssgs_pkg::ST_PROD].gain;
    out_d.saturated = sat_re || sat_im;
  end

  // Each stage loads whenever it is empty or the stage after it can load.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (free[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int s = 1; s < ssgs_pkg::STAGES; s++) begin
        if (free[s]) begin
          valid_q[s] <= valid_q[s-1];
        end
      end
      if (out_free) begin
        out_valid_q <= valid_q[ssgs_pkg::STAGES-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < ssgs_pkg::STAGES; s++) begin
      if (free[s]) begin
        pipe_q[s] <= pipe_d[s];
      end
    end
    if (out_free) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

>>> verif/tb.sv
// Testbench for the spectral site gain shaper: drives bins through the
// valid/ready ports, predicts each result and compares it. Depends on ssgs_pkg.
module tb;

  // Scoreboard: computes the expected scaled bin from its own register copy
  // and holds the results still to come, oldest first.
  class gain_scoreboard;
    logic [15:0]         regs [8];
    ssgs_pkg::out_item_t pending [$];
    int                  errors;

    function new();
      errors = 0;
      regs[ssgs_pkg::REG_CORNER_LOW]        = 16'd0;
      regs[ssgs_pkg::REG_CORNER_MID_BOTTOM] = 16'd0;
      regs[ssgs_pkg::REG_CORNER_MID]        = 16'd0;
      regs[ssgs_pkg::REG_CORNER_HIGH]       = 16'd0;
      regs[ssgs_pkg::REG_CORNER_HIGH_TOP]   = 16'd2048;
      regs[ssgs_pkg::REG_CORNER_MAX]        = 16'd2048;
      regs[ssgs_pkg::REG_GAIN_SHORT]        = 16'd4096;
      regs[ssgs_pkg::REG_GAIN_LONG]         = 16'd4096;
    endfunction

    function void write_reg(int idx, logic [15:0] val);
      if (idx <= ssgs_pkg::REG_GAIN_LONG)
        regs[idx] = (idx <= ssgs_pkg::REG_CORNER_MAX) ? (val & 16'h0fff) : val;
    endfunction

    function longint ramp_gain(longint i, longint c0, longint c1, longint a, longint b);
      return a + ((i - c0) * (b - a)) / (c1 - c0);
    endfunction

    function longint bin_gain(longint i);
      longint lo, mb, md, hi, ht, mx, gs, gl, u;
      lo = regs[ssgs_pkg::REG_CORNER_LOW];
      mb = regs[ssgs_pkg::REG_CORNER_MID_BOTTOM];
      md = regs[ssgs_pkg::REG_CORNER_MID];
      hi = regs[ssgs_pkg::REG_CORNER_HIGH];
      ht = regs[ssgs_pkg::REG_CORNER_HIGH_TOP];
      mx = regs[ssgs_pkg::REG_CORNER_MAX];
      gs = regs[ssgs_pkg::REG_GAIN_SHORT];
      gl = regs[ssgs_pkg::REG_GAIN_LONG];
      u  = ssgs_pkg::UNITY_GAIN;
      if (i == 0 || i >= ssgs_pkg::FFT_SIZE / 2) return u;
      if (lo > mb) lo = mb;
      if (mx < ht) mx = ht;
      if (i < lo) return u;
      if (i < mb) return ramp_gain(i, lo, mb, u, gl);
      if (i < md) return gl;
      if (i < hi) return ramp_gain(i, md, hi, gl, gs);
      if (i < ht) return gs;
      if (i < mx) return ramp_gain(i, ht, mx, gs, u);
      return u;
    endfunction

    // Round to nearest with ties up, then clip to 32 bits.
    function logic [31:0] scale_part(longint x, longint g, inout logic clipped);
      longint q;
      q = x * g + 2048;
      q = q >>> 12;
      if (q > 64'sd2147483647) begin
        q = 64'sd2147483647;
        clipped = 1'b1;
      end else if (q < -64'sd2147483648) begin
        q = -64'sd2147483648;
        clipped = 1'b1;
      end
      return q[31:0];
    endfunction

    function void note_bin(ssgs_pkg::in_item_t it);
      ssgs_pkg::out_item_t e;
      longint g;
      logic clipped;
      clipped = 1'b0;
      g = bin_gain(longint'(it.bin_index));
      e.scaled_re = scale_part(longint'(it.spec_re), g, clipped);
      e.scaled_im = scale_part(longint'(it.spec_im), g, clipped);
      e.gain_used = g[15:0];
      e.saturated = clipped;
      pending.push_back(e);
    endfunction

    function void check_result(ssgs_pkg::out_item_t got);
      ssgs_pkg::out_item_t e;
      if (pending.size() == 0) begin
        $error("unexpected result re=%0d im=%0d", got.scaled_re, got.scaled_im);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.scaled_re !== e.scaled_re) begin
        $error("scaled_re expected %0d got %0d", e.scaled_re, got.scaled_re);
        errors++;
      end
      if (got.scaled_im !== e.scaled_im) begin
        $error("scaled_im expected %0d got %0d", e.scaled_im, got.scaled_im);
        errors++;
      end
      if (got.gain_used !== e.gain_used) begin
        $error("gain_used expected %0d got %0d", e.gain_used, got.gain_used);
        errors++;
      end
      if (got.saturated !== e.saturated) begin
        $error("saturated expected %0b got %0b", e.saturated, got.saturated);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  ssgs_pkg::in_item_t  in_item;
  ssgs_pkg::out_item_t out_item;
  logic cfg_we;
  logic [ssgs_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [ssgs_pkg::CFG_DATA_W-1:0] cfg_wdata;

  gain_scoreboard sb;
  int send_idle_pct, recv_stall_pct;
  longint cycles;

  spectral_site_gain_shaper u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_item_i(in_item),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_item_o(out_item),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Inputs are registered into the predictor and outputs checked at the
  // rising edge; drivers only change things at the falling edge.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_bin(in_item);
    if (rst_n && out_valid && out_ready) sb.check_result(out_item);
  end

  // The receiver stalls at random according to the current phase.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: the slowest correct run is well under this many cycles.
  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Sends one item; valid stays high until it is taken and stays up for a
  // following item sent back to back. Random idle cycles may be inserted
  // beforehand so gaps land on every pipeline phase.
  task automatic send_bin(logic [10:0] bin, logic [31:0] re, logic [31:0] im);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    end
    in_item.bin_index <= bin;
    in_item.spec_re   <= re;
    in_item.spec_im   <= im;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    stop_sending();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  // Write enable stays high across a run of writes; load_corners drops it.
  task automatic write_reg(ssgs_pkg::cfg_reg_e idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    sb.write_reg(int'(idx), val);
    @(negedge clk);
  endtask

  task automatic load_corners(int lo, int mb, int md, int hi, int ht, int mx,
                              int gs, int gl);
    write_reg(ssgs_pkg::REG_CORNER_LOW, 16'(lo));
    write_reg(ssgs_pkg::REG_CORNER_MID_BOTTOM, 16'(mb));
    write_reg(ssgs_pkg::REG_CORNER_MID, 16'(md));
    write_reg(ssgs_pkg::REG_CORNER_HIGH, 16'(hi));
    write_reg(ssgs_pkg::REG_CORNER_HIGH_TOP, 16'(ht));
    write_reg(ssgs_pkg::REG_CORNER_MAX, 16'(mx));
    write_reg(ssgs_pkg::REG_GAIN_SHORT, 16'(gs));
    write_reg(ssgs_pkg::REG_GAIN_LONG, 16'(gl));
    cfg_we <= 1'b0;
  endtask

  // Random corners, ordered most of the time, occasionally scrambled or
  // beyond the bin range to reach the clamps and unordered-corner paths.
  task automatic random_corners();
    int c [6];
    int t;
    for (int k = 0; k < 6; k++) c[k] = $urandom_range(2047);
    if ($urandom_range(3) != 0) begin
      for (int a = 0; a < 6; a++)
        for (int b = a + 1; b < 6; b++)
          if (c[b] < c[a]) begin
            t = c[a]; c[a] = c[b]; c[b] = t;
          end
    end
    if ($urandom_range(4) == 0) c[$urandom_range(5)] = $urandom_range(4095);
    load_corners(c[0], c[1], c[2], c[3], c[4], c[5],
                 $urandom_range(65535), $urandom_range(65535));
  endtask

  function automatic logic [31:0] rand_data();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(4095) - 2048;
      default: return $urandom;
    endcase
  endfunction

  // One burst of random bins under the current settings and idling phase.
  task automatic random_burst(int n);
    for (int k = 0; k < n; k++)
      send_bin(($urandom_range(9) == 0) ? 11'd0 : 11'($urandom),
               rand_data(), rand_data());
  endtask

  initial begin
    sb = new();
    cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    in_valid = 1'b0;
    in_item = '0;
    out_ready = 1'b1;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    rst_n = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: reset settings give unity over the full range; DC bin
    // with extreme values, the top bin and a saturating long gain.
    send_bin(11'd0, 32'h7fffffff, 32'h80000000);
    send_bin(11'd2047, 32'h80000000, 32'h7fffffff);
    drain();
    load_corners(100, 200, 300, 400, 500, 600, 16'hffff, 16'h2000);
    send_bin(11'd0, 32'h7fffffff, 32'h80000000);
    send_bin(11'd50, 32'd12345, -32'd12345);
    send_bin(11'd100, 32'h7fffffff, 32'h80000000);
    send_bin(11'd150, 32'h7fffffff, 32'h80000000);
    send_bin(11'd250, 32'd2047, -32'd2049);
    send_bin(11'd350, 32'h80000000, 32'd1);
    send_bin(11'd450, 32'hffffffff, 32'd1);
    send_bin(11'd550, 32'd3, -32'd3);
    send_bin(11'd600, 32'h7fffffff, 32'h80000000);
    send_bin(11'd1024, -32'd1, 32'd0);
    send_bin(11'd1500, 32'h55555555, 32'haaaaaaaa);
    drain();
    // Clamps: low corner above the mid-bottom corner, max below the top one;
    // zero gains and all-ones corners for the opposite extremes.
    load_corners(900, 300, 299, 250, 1800, 1000, 0, 16'h0800);
    send_bin(11'd100, 32'h7fffffff, 32'h80000000);
    send_bin(11'd299, 32'd1000, -32'd1000);
    send_bin(11'd1700, 32'd1000, -32'd1000);
    send_bin(11'd2046, 32'd1000, -32'd1000);
    drain();
    load_corners(12'hfff, 12'hfff, 12'hfff, 12'hfff, 12'hfff, 12'hfff, 0, 0);
    send_bin(11'd1, 32'd777, 32'd777);
    send_bin(11'd2047, 32'd777, 32'd777);
    drain();

    // Random phases: no idling, sender idle, receiver stalling, both.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 45 : (ph == 3) ? 21 : 0;
      recv_stall_pct = (ph == 2) ? 45 : (ph == 3) ? 21 : 0;
      for (int s = 0; s < 4; s++) begin
        random_corners();
        random_burst(26);
        drain();
      end
      // Sender holds off until the pipeline is empty, then continues.
      random_burst(5);
      stop_sending();
      while (sb.pending.size() != 0) @(negedge clk);
      random_burst(5);
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

>>> filelist.f
rtl/core/ssgs_pkg.sv
rtl/core/spectral_site_gain_shaper.sv
verif/tb.sv
